// ----- rtl/point_in_polygon_test_unit_assert.svh -----
// Assertion macros shared by the point-in-polygon test unit.
`ifndef POINT_IN_POLYGON_TEST_UNIT_ASSERT_SVH
`define POINT_IN_POLYGON_TEST_UNIT_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define PIP_ASSERT_IMP(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define PIP_ASSERT_NXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("assertion failed");
`endif

// ----- rtl/pip_pkg.sv -----
//------------------------------------------------------------------------------
// pip_pkg
// Shared types for the point-in-polygon test unit.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package pip_pkg;
   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_BOX   = 7'b0000010,
      ST_BCHK  = 7'b0000100,
      ST_EDGE  = 7'b0001000,
      ST_DRAIN = 7'b0010000,
      ST_RSP   = 7'b0100000,
      ST_WAIT  = 7'b1000000
   } pip_state_type;

   typedef struct packed {
      logic load_pt;   // capture query point
      logic box_init;  // start of the box pass
      logic box_step;  // fold one vertex into the box
      logic edge_init; // start of the edge pass
      logic edge_step; // issue one edge
      logic rsp_load;  // capture result
      logic force_out; // result is outside box
   } pip_cmd_type;

   typedef struct packed {
      logic box_last;
      logic box_reject;
      logic edge_last;
      logic pipe_empty;
   } pip_sts_type;
endpackage

// ----- rtl/pip_ctrl.sv -----
//------------------------------------------------------------------------------
// pip_ctrl
// Sequencer for the box pass, the edge pass and the response handshake.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "point_in_polygon_test_unit_assert.svh"
module pip_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 query_go,
   input  logic                 count_zero,
   input  logic                 rsp_stall,
   input  pip_pkg::pip_sts_type sts,
   output pip_pkg::pip_cmd_type cmd,
   output logic                 busy,
   output logic                 rsp_valid
);
   import pip_pkg::*;
   pip_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (query_go) begin
               cmd.load_pt = 1'b1;
               if (count_zero) begin
                  cmd.rsp_load = 1'b1;
                  cmd.force_out = 1'b1;
                  state_in = ST_RSP;
               end else begin
                  cmd.box_init = 1'b1;
                  state_in = ST_BOX;
               end
            end
         end
         ST_BOX: begin
            cmd.box_step = 1'b1;
            if (sts.box_last) state_in = ST_WAIT;
         end
         ST_WAIT: state_in = ST_BCHK;
         ST_BCHK: begin
            if (sts.box_reject) begin
               cmd.rsp_load = 1'b1;
               cmd.force_out = 1'b1;
               state_in = ST_RSP;
            end else begin
               cmd.edge_init = 1'b1;
               state_in = ST_EDGE;
            end
         end
         ST_EDGE: begin
            cmd.edge_step = 1'b1;
            if (sts.edge_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (sts.pipe_empty) begin
               cmd.rsp_load = 1'b1;
               state_in = ST_RSP;
            end
         end
         ST_RSP: if (!rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RSP);

   `PIP_ASSERT_IMP(a_onehot, clock, reset, 1'b1, $onehot(state_ff))
   `PIP_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `PIP_ASSERT_NXT(a_drain_done, clock, reset,
      (state_ff == ST_DRAIN) && sts.pipe_empty, rsp_valid)
endmodule

// ----- rtl/pip_dp.sv -----
//------------------------------------------------------------------------------
// pip_dp
// Vertex store, bounding box, and pipelined edge crossing test with a
// bit-serial style divider unrolled over registered stages.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module pip_dp #(
   parameter int MAX_VERTICES = 64,
   parameter int COORD_BITS   = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [5:0]           wr_index,
   input  logic [15:0]          in_x,
   input  logic [15:0]          in_y,
   input  logic [6:0]           count,
   input  pip_pkg::pip_cmd_type cmd,
   output pip_pkg::pip_sts_type sts,
   output logic                 count_zero,
   output logic                 inside_ff,
   output logic                 outbox_ff
);
   import pip_pkg::*;
   localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CW = AW + 1;
   localparam int DW = COORD_BITS + 1;      // difference width
   localparam int PW = 2 * DW;              // product magnitude width
   localparam int QS = PW;                  // divider stages, one bit each

   logic signed [COORD_BITS-1:0] mem_x [MAX_VERTICES];
   logic signed [COORD_BITS-1:0] mem_y [MAX_VERTICES];
   logic signed [COORD_BITS-1:0] rdx_ff, rdy_ff;

   // Incoming coordinates at the working width.
   logic signed [COORD_BITS-1:0] in_xc, in_yc;
   assign in_xc = COORD_BITS'(in_x);
   assign in_yc = COORD_BITS'(in_y);

   // Effective vertex count, saturated.
   logic [CW-1:0] n_eff;
   always_comb begin
      if ({25'd0, count} > MAX_VERTICES) n_eff = CW'(MAX_VERTICES);
      else n_eff = CW'(count);
   end
   assign count_zero = (count == 7'd0);

   logic          wr_ok;
   logic [AW-1:0] wr_addr;
   assign wr_ok = wr_en && ({26'd0, wr_index} < MAX_VERTICES);
   assign wr_addr = AW'(wr_index);
   always_ff @(posedge clock) begin
      if (wr_ok) begin
         mem_x[wr_addr] <= in_xc;
         mem_y[wr_addr] <= in_yc;
      end
   end

   // Query point.
   logic signed [COORD_BITS-1:0] px_ff, py_ff;
   always_ff @(posedge clock) begin
      if (cmd.load_pt) begin
         px_ff <= in_xc;
         py_ff <= in_yc;
      end
   end

   // Read address counter shared by both passes.
   logic [CW-1:0] addr_ff, addr_in;
   logic          first_ff;    // first vertex of box pass
   always_comb begin
      addr_in = addr_ff;
      if (cmd.box_init) addr_in = '0;
      else if (cmd.edge_init) addr_in = '0;
      else if (cmd.box_step || cmd.edge_step) addr_in = addr_ff + 1'b1;
   end
   always_ff @(posedge clock) begin
      if (reset) addr_ff <= '0;
      else addr_ff <= addr_in;
   end
   always_ff @(posedge clock) begin
      rdx_ff <= mem_x[addr_ff[AW-1:0]];
      rdy_ff <= mem_y[addr_ff[AW-1:0]];
   end
   assign sts.box_last  = (addr_ff == n_eff - 1'b1);
   assign sts.edge_last = (addr_ff == n_eff);

   // Bounding box pass: the read data arrives in the cycle after its address.
   logic box_vld_ff;
   logic signed [COORD_BITS-1:0] minx_ff, maxx_ff, miny_ff, maxy_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         box_vld_ff <= 1'b0;
         first_ff <= 1'b0;
      end else begin
         box_vld_ff <= cmd.box_step;
         if (cmd.box_init) first_ff <= 1'b1;
         else if (box_vld_ff) first_ff <= 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (box_vld_ff) begin
         if (first_ff || rdx_ff < minx_ff) minx_ff <= rdx_ff;
         if (first_ff || rdx_ff > maxx_ff) maxx_ff <= rdx_ff;
         if (first_ff || rdy_ff < miny_ff) miny_ff <= rdy_ff;
         if (first_ff || rdy_ff > maxy_ff) maxy_ff <= rdy_ff;
      end
   end
   assign sts.box_reject = (px_ff < minx_ff) || (px_ff > maxx_ff) ||
                           (py_ff < miny_ff) || (py_ff > maxy_ff);

   // Edge pass: address 0 reads the closing vertex's partner; the previous
   // vertex of entry 0 is the last one, so the first read is held as the
   // wrap vertex and edges are formed as (prev, cur), last edge closes.
   logic edge_vld_ff;
   logic [CW-1:0] eidx_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         edge_vld_ff <= 1'b0;
         eidx_ff <= '0;
      end else begin
         edge_vld_ff <= cmd.edge_step;
         eidx_ff <= addr_ff;
      end
   end
   logic signed [COORD_BITS-1:0] prvx_ff, prvy_ff, v0x_ff, v0y_ff;
   logic signed [COORD_BITS-1:0] curx, cury;
   logic                         e_fire;
   always_comb begin
      curx = rdx_ff;
      cury = rdy_ff;
      if (eidx_ff == n_eff) begin
         curx = v0x_ff;
         cury = v0y_ff;
      end
   end
   assign e_fire = edge_vld_ff && (eidx_ff != '0);
   always_ff @(posedge clock) begin
      if (edge_vld_ff) begin
         prvx_ff <= curx;
         prvy_ff <= cury;
         if (eidx_ff == '0) begin
            v0x_ff <= rdx_ff;
            v0y_ff <= rdy_ff;
         end
      end
   end

   // Stage A: differences and straddle test. The current vertex is i and the
   // previous one is j; the truncated quotient depends on that order.
   logic               a_vld_ff, a_str_ff;
   logic signed [DW-1:0] a_dx_ff, a_dp_ff, a_dy_ff;
   logic signed [DW-1:0] a_xi_ff;
   always_ff @(posedge clock) begin
      if (reset) a_vld_ff <= 1'b0;
      else a_vld_ff <= e_fire;
      a_str_ff <= (prvy_ff > py_ff) != (cury > py_ff);
      a_dx_ff <= DW'(prvx_ff) - DW'(curx);
      a_dp_ff <= DW'(py_ff) - DW'(cury);
      a_dy_ff <= DW'(prvy_ff) - DW'(cury);
      a_xi_ff <= DW'(curx);
   end

   // Stage B: signed-magnitude product.
   logic               b_vld_ff, b_str_ff, b_neg_ff;
   logic [PW-1:0]      b_prod_ff;
   logic [DW-1:0]      b_den_ff;
   logic signed [DW-1:0] b_xi_ff;
   logic [DW-1:0]      mdx, mdp;
   assign mdx = a_dx_ff[DW-1] ? DW'(-a_dx_ff) : DW'(a_dx_ff);
   assign mdp = a_dp_ff[DW-1] ? DW'(-a_dp_ff) : DW'(a_dp_ff);
   always_ff @(posedge clock) begin
      if (reset) b_vld_ff <= 1'b0;
      else b_vld_ff <= a_vld_ff;
      b_str_ff <= a_str_ff;
      b_neg_ff <= (a_dx_ff[DW-1] ^ a_dp_ff[DW-1]) ^ a_dy_ff[DW-1];
      b_prod_ff <= PW'(mdx) * PW'(mdp);
      b_den_ff <= a_dy_ff[DW-1] ? DW'(-a_dy_ff) : DW'(a_dy_ff);
      b_xi_ff <= a_xi_ff;
   end

   // Restoring divider, one quotient bit per registered stage.
   logic            d_vld [QS+1];
   logic            d_str [QS+1];
   logic            d_neg [QS+1];
   logic [PW-1:0]   d_num [QS+1];
   logic [PW-1:0]   d_rem [QS+1];
   logic [PW-1:0]   d_quo [QS+1];
   logic [DW-1:0]   d_den [QS+1];
   logic signed [DW-1:0] d_xi [QS+1];
   assign d_vld[0] = b_vld_ff;
   assign d_str[0] = b_str_ff;
   assign d_neg[0] = b_neg_ff;
   assign d_num[0] = b_prod_ff;
   assign d_rem[0] = '0;
   assign d_quo[0] = '0;
   assign d_den[0] = b_den_ff;
   assign d_xi[0]  = b_xi_ff;

   genvar g;
   generate
      for (g = 0; g < QS; g++) begin : g_div
         logic [PW:0]   trial;
         logic [PW-1:0] shr;
         logic          vld_ff, str_ff, neg_ff;
         logic [PW-1:0] num_ff, rem_ff, quo_ff;
         logic [DW-1:0] den_ff;
         logic signed [DW-1:0] xi_ff;
         assign shr = {d_rem[g][PW-2:0], d_num[g][PW-1]};
         assign trial = {1'b0, shr} - {1'b0, {(PW-DW){1'b0}}, d_den[g]};
         always_ff @(posedge clock) begin
            if (reset) vld_ff <= 1'b0;
            else vld_ff <= d_vld[g];
            str_ff <= d_str[g];
            neg_ff <= d_neg[g];
            den_ff <= d_den[g];
            xi_ff  <= d_xi[g];
            num_ff <= {d_num[g][PW-2:0], 1'b0};
            if (!trial[PW]) begin
               rem_ff <= trial[PW-1:0];
               quo_ff <= {d_quo[g][PW-2:0], 1'b1};
            end else begin
               rem_ff <= shr;
               quo_ff <= {d_quo[g][PW-2:0], 1'b0};
            end
         end
         assign d_vld[g+1] = vld_ff;
         assign d_str[g+1] = str_ff;
         assign d_neg[g+1] = neg_ff;
         assign d_num[g+1] = num_ff;
         assign d_rem[g+1] = rem_ff;
         assign d_quo[g+1] = quo_ff;
         assign d_den[g+1] = den_ff;
         assign d_xi[g+1]  = xi_ff;
      end
   endgenerate

   // Final compare and parity toggle. |q| <= |dx|, so DW+1 bits suffice.
   logic signed [DW+1:0] qv, xint;
   logic                 par_ff;
   always_comb begin
      qv = (DW+2)'(signed'({1'b0, d_quo[QS][DW-1:0]}));
      if (d_neg[QS]) qv = -qv;
      xint = qv + (DW+2)'(d_xi[QS]);
   end
   always_ff @(posedge clock) begin
      if (reset || cmd.edge_init) par_ff <= 1'b0;
      else if (d_vld[QS] && d_str[QS] && ((DW+2)'(px_ff) < xint)) par_ff <= ~par_ff;
   end

   // Pipeline occupancy.
   logic [CW+7:0] fly_ff;
   always_ff @(posedge clock) begin
      if (reset) fly_ff <= '0;
      else fly_ff <= fly_ff + (CW+8)'(e_fire) - (CW+8)'(d_vld[QS]);
   end
   assign sts.pipe_empty = (fly_ff == '0) && !edge_vld_ff;

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         inside_ff <= cmd.force_out ? 1'b0 : par_ff;
         outbox_ff <= cmd.force_out;
      end
   end
endmodule

// ----- rtl/point_in_polygon_test_unit.sv -----
// Point-in-polygon test unit.
// A query runs the box pass and box check, then the edge pass, the difference and
// product stages and the 34-stage divider drain; a box reject answers after the box
// check and a zero count from idle without either pass. One query at a time: the next
// request is taken the cycle after the response; a vertex write completes when taken.
// Reset (synchronous, active high) clears the control state and vertex count.
//------------------------------------------------------------------------------
// point_in_polygon_test_unit
// Crossing-parity point-in-polygon test over a stored polygon.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module point_in_polygon_test_unit #(
   parameter int MAX_VERTICES = 64,
   parameter int COORD_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [6:0]  csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [5:0]  req_vertex_index,
   input  logic [15:0] req_coord_x,
   input  logic [15:0] req_coord_y,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_inside_res,
   output logic        rsp_outside_box
);
   import pip_pkg::*;

   // The vertex count register; it is to be written only while the unit is idle.
   logic [6:0] count_ff;
   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else if (csr_write) count_ff <= csr_wdata;
   end

   pip_cmd_type cmd;
   pip_sts_type sts;
   logic        busy, count_zero, acc;

   // Requests are taken whenever the sequencer is idle; writes finish at once.
   assign req_stall = busy;
   assign acc = req_valid && !busy;

   pip_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .query_go   (acc && req_type),
      .count_zero (count_zero),
      .rsp_stall  (rsp_stall),
      .sts        (sts),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_valid  (rsp_valid)
   );

   pip_dp #(
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_BITS   (COORD_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (acc && !req_type),
      .wr_index   (req_vertex_index),
      .in_x       (req_coord_x),
      .in_y       (req_coord_y),
      .count      (count_ff),
      .cmd        (cmd),
      .sts        (sts),
      .count_zero (count_zero),
      .inside_ff  (rsp_inside_res),
      .outbox_ff  (rsp_outside_box)
   );
endmodule

// ----- dv/tb.sv -----
//------------------------------------------------------------------------------
// tb
// Self-checking bench for the point-in-polygon test unit. Vertex writes and
// point queries are fed through the request channel. A local crossing-parity
// predictor computes each query's expected response. The monitor compares
// every accepted response with the oldest expected one.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
   localparam int NV = 64;
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [5:0]  index;
      logic [15:0] x;
      logic [15:0] y;
   } poly_req_type;

   typedef struct packed {
      logic in_poly;
      logic outside;
   } poly_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write = 1'b0;
   logic [6:0]  csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_type = 1'b0;
   logic [5:0]  req_vertex_index = '0;
   logic [15:0] req_coord_x = '0;
   logic [15:0] req_coord_y = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_inside_res;
   logic        rsp_outside_box;

   point_in_polygon_test_unit DUT (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
      .req_vertex_index(req_vertex_index), .req_coord_x(req_coord_x),
      .req_coord_y(req_coord_y),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_inside_res(rsp_inside_res), .rsp_outside_box(rsp_outside_box)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Predictor state: its own copy of the polygon store and the count.
   logic signed [15:0] poly_x [NV];
   logic signed [15:0] poly_y [NV];
   logic [6:0]         poly_count;

   poly_req_type pending_reqs [$];
   poly_rsp_type expected_rsps [$];

   int  errors = 0;
   int  queries_sent = 0;
   int  rsps_seen = 0;
   int  send_idle_pct = 0;
   int  stall_pct = 0;
   bit  hold_requests = 1'b0;

   // Crossing-parity answer for a point against the predictor's polygon.
   function automatic poly_rsp_type classify_point(logic signed [15:0] px,
                                                   logic signed [15:0] py);
      poly_rsp_type r;
      int n, i, j;
      longint minx, maxx, miny, maxy;
      longint xi, yi, xj, yj, dx, dp, dy, q;
      bit c;
      r = '0;
      c = 1'b0;
      n = (poly_count > NV) ? NV : poly_count;
      if (n == 0) begin
         r.outside = 1'b1;
         return r;
      end
      minx = poly_x[0]; maxx = poly_x[0];
      miny = poly_y[0]; maxy = poly_y[0];
      for (i = 1; i < n; i++) begin
         if (poly_x[i] < minx) minx = poly_x[i];
         if (poly_x[i] > maxx) maxx = poly_x[i];
         if (poly_y[i] < miny) miny = poly_y[i];
         if (poly_y[i] > maxy) maxy = poly_y[i];
      end
      if (px < minx || px > maxx || py < miny || py > maxy) begin
         r.outside = 1'b1;
         return r;
      end
      j = n - 1;
      for (i = 0; i < n; i++) begin
         xi = poly_x[i]; yi = poly_y[i];
         xj = poly_x[j]; yj = poly_y[j];
         if ((yi > py) != (yj > py)) begin
            dx = xj - xi;
            dp = py - yi;
            dy = yj - yi;
            // SystemVerilog division already truncates toward zero.
            q = (dx * dp) / dy;
            if (px < q + xi) c = ~c;
         end
         j = i;
      end
      r.in_poly = c;
      return r;
   endfunction

   // Driver: present the head of the pending queue, hold it while stalled.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            poly_req_type a;
            a = pending_reqs.pop_front();
            if (a.kind == REQ_WRITE) begin
               poly_x[a.index] = a.x;
               poly_y[a.index] = a.y;
            end else begin
               expected_rsps = {expected_rsps, classify_point(a.x, a.y)};
            end
         end
         if (req_valid && req_stall) begin
            // Stalled payload stays as it is.
         end else if (pending_reqs.size() > 0 && !hold_requests &&
                      $urandom_range(99, 0) >= send_idle_pct) begin
            req_valid        <= 1'b1;
            req_type         <= pending_reqs[0].kind;
            req_vertex_index <= pending_reqs[0].index;
            req_coord_x      <= pending_reqs[0].x;
            req_coord_y      <= pending_reqs[0].y;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: compare each accepted response with the oldest expectation.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            poly_rsp_type e;
            rsps_seen++;
            if (expected_rsps.size() == 0) begin
               $display("%0t: response expected none actual inside=%0b outside=%0b",
                        $time, rsp_inside_res, rsp_outside_box);
               errors++;
            end else begin
               e = expected_rsps.pop_front();
               if (e.in_poly !== rsp_inside_res) begin
                  $display("%0t: inside_res expected %0b actual %0b", $time,
                           e.in_poly, rsp_inside_res);
                  errors++;
               end
               if (e.outside !== rsp_outside_box) begin
                  $display("%0t: outside_box expected %0b actual %0b", $time,
                           e.outside, rsp_outside_box);
                  errors++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99, 0) < stall_pct);
      end
   end

   function automatic logic [15:0] rand_coord();
      case ($urandom_range(5, 0))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'(int'($urandom_range(40, 0)) - 20);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic add_req(logic kind, logic [5:0] idx, logic [15:0] x, logic [15:0] y);
      poly_req_type r;
      r.kind  = kind;
      r.index = idx;
      r.x     = x;
      r.y     = y;
      pending_reqs = {pending_reqs, r};
      if (kind == REQ_QUERY) queries_sent++;
   endtask

   // Wait until the queue is drained and no response is outstanding; the
   // trailing cycles cover a query still in flight before a count change.
   task automatic wait_idle();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic set_count(logic [6:0] n);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_wdata <= n;
      @(posedge clock);
      csr_write <= 1'b0;
      poly_count = n;
   endtask

   // Write a random polygon into entries 0..n-1 so that every entry in use
   // has been written; small coordinates give frequent inside points.
   task automatic load_polygon(int n, int span);
      for (int k = 0; k < n; k++) begin
         logic [15:0] x, y;
         if (span == 0) begin
            x = rand_coord(); y = rand_coord();
         end else begin
            x = 16'($signed($urandom_range(2 * span, 0)) - span);
            y = 16'($signed($urandom_range(2 * span, 0)) - span);
         end
         add_req(REQ_WRITE, 6'(k), x, y);
      end
   endtask

   task automatic add_queries(int m, int span);
      for (int k = 0; k < m; k++) begin
         logic [15:0] x, y;
         if (span == 0 || $urandom_range(3, 0) == 0) begin
            x = rand_coord(); y = rand_coord();
         end else begin
            x = 16'($signed($urandom_range(2 * span, 0)) - span);
            y = 16'($signed($urandom_range(2 * span, 0)) - span);
         end
         // Random index bits on queries show that the block ignores them.
         add_req(REQ_QUERY, 6'($urandom), x, y);
      end
   endtask

   initial begin
      int n, span, phase;
      for (int k = 0; k < NV; k++) begin
         poly_x[k] = '0;
         poly_y[k] = '0;
      end
      poly_count = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero vertices gives outside.
      add_queries(2, 0);
      wait_idle();

      // Directed: a square with extreme corners, points on edges and corners.
      add_req(REQ_WRITE, 6'd0, 16'h8000, 16'h8000);
      add_req(REQ_WRITE, 6'd1, 16'h7FFF, 16'h8000);
      add_req(REQ_WRITE, 6'd2, 16'h7FFF, 16'h7FFF);
      add_req(REQ_WRITE, 6'd3, 16'h8000, 16'h7FFF);
      add_req(REQ_WRITE, 6'd63, 16'h1234, 16'hEDCB);
      wait_idle();
      set_count(7'd4);
      add_req(REQ_QUERY, 6'd0, 16'h0000, 16'h0000);
      add_req(REQ_QUERY, 6'd63, 16'h8000, 16'h8000);
      add_req(REQ_QUERY, 6'd5, 16'h7FFF, 16'h7FFF);
      add_req(REQ_QUERY, 6'd0, 16'h8000, 16'h0000);
      add_req(REQ_QUERY, 6'd0, 16'h7FFF, 16'h0000);
      add_req(REQ_QUERY, 6'd0, 16'h0000, 16'h7FFF);
      wait_idle();

      // Directed: a triangle, with points on both sides and outside the box.
      add_req(REQ_WRITE, 6'd0, 16'd0, 16'd0);
      add_req(REQ_WRITE, 6'd1, 16'd10, 16'd0);
      add_req(REQ_WRITE, 6'd2, 16'd0, 16'd10);
      wait_idle();
      set_count(7'd3);
      add_req(REQ_QUERY, 6'd0, 16'd2, 16'd2);
      add_req(REQ_QUERY, 6'd0, 16'd9, 16'd9);
      add_req(REQ_QUERY, 6'd0, 16'd11, 16'd1);
      add_req(REQ_QUERY, 6'd0, 16'hFFFF, 16'd1);
      wait_idle();

      // Directed: a count above the store size saturates; fill all entries.
      load_polygon(NV, 100);
      wait_idle();
      set_count(7'd127);
      add_queries(3, 100);
      wait_idle();

      // Random phases over idling profiles and polygon sizes.
      for (phase = 0; phase < 21; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 61; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 61; end
            default: begin send_idle_pct = 15; stall_pct = 15; end
         endcase
         if (phase % 6 == 5) n = $urandom_range(64, 33);
         else n = $urandom_range(12, 1);
         span = ($urandom_range(1, 0) == 1) ? 50 : 0;
         load_polygon(n, span);
         wait_idle();
         set_count(7'(n));
         add_queries(20, span);
         if (phase == 10) begin
            // Let the sender pause until every expected response is in.
            while (pending_reqs.size() > 0 || req_valid) @(posedge clock);
            hold_requests = 1'b1;
            while (expected_rsps.size() > 0) @(posedge clock);
            hold_requests = 1'b0;
            add_queries(5, span);
         end
         // Some overwrites of live entries mixed into the query stream.
         for (int k = 0; k < 4; k++) begin
            add_req(REQ_WRITE, 6'($urandom_range(n - 1, 0)), rand_coord(), rand_coord());
            add_queries(3, span);
         end
         wait_idle();
      end

      $display("Covered %0d queries (%0d responses) over polygons of 0 to 64 vertices,",
               queries_sent, rsps_seen);
      $display("with saturated counts, extreme coordinates and random idling and stalls.");
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("Test completed with failures");
      $finish;
   end
endmodule

// ----- files.f -----
+incdir+rtl
rtl/pip_pkg.sv
rtl/pip_ctrl.sv
rtl/pip_dp.sv
rtl/point_in_polygon_test_unit.sv
dv/tb.sv
